/* hdl/deq_pkg.sv */
// shared types and codes for the double-ended queue
package deq_pkg;

  // operation codes carried in an input word
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  // error codes carried in a result word
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // request word
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] push_value;
  } deq_in_t;

  // result word
  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         error_code;
    logic [4:0]         count;
    logic               empty_flag;
  } deq_out_t;

endpackage

/* hdl/deq_ram.sv */
// ring storage: one write port, one read port with registered read data
module deq_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/double_ended_queue.sv */
// double-ended queue of signed words in a ring memory with front pointer and count
//
//   port group   direction  handshake                 word type
//   in           in         in_valid_i / in_ready_o   deq_pkg::deq_in_t
//   out          out        out_valid_o / out_ready_i deq_pkg::deq_out_t
//
// Every accepted word gives exactly one result word, via the in-flight registers
// and the output register. Pointer and count update at acceptance; pops read the
// ring memory, whose registered read data sets the result delay. With out_ready_i
// high the block takes one word per cycle. A stalled result is held in the output
// register and one more word may be taken, which then waits for the output register.
// Reset clears the pointer, the count and all handshake state; the ring memory is
// not cleared, since an entry is only read after it was written.
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  deq_pkg::deq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_out_t out_data_o
);
  import deq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

  // architectural state
  logic [PTR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  // word in flight, waiting for read data
  logic             busy_q, busy_d;
  logic             pop_ok_q;
  err_e             err_q;
  logic [CNT_W-1:0] res_cnt_q;

  // output register
  logic     out_valid_q, out_valid_d;
  deq_out_t out_q;

  // decode signals
  logic             accept, done;
  logic             full, empty;
  logic [PTR_W-1:0] front_dec, front_inc;
  logic [SUM_W-1:0] back_sum, last_sum;
  logic [SUM_W-1:0] back_wrap, last_wrap;
  logic [PTR_W-1:0] back_idx, last_idx;
  logic [PTR_W-1:0] op_front;
  logic [CNT_W-1:0] op_count;
  logic             op_we, op_re, op_pop_ok;
  err_e             op_err;
  logic [PTR_W-1:0] waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;

  // handshake
  assign done       = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || done;
  assign accept     = in_valid_i && in_ready_o;

  // ring index arithmetic
  assign full      = (count_q == FULL_CNT);
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - PTR_W'(1);
  assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + PTR_W'(1);
  assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
  assign last_sum  = back_sum - SUM_W'(1);
  assign back_wrap = (back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum;
  assign last_wrap = (last_sum >= DEPTH_S) ? last_sum - DEPTH_S : last_sum;
  assign back_idx  = back_wrap[PTR_W-1:0];
  assign last_idx  = last_wrap[PTR_W-1:0];

  // operation decode
  always_comb begin
    op_front  = front_q;
    op_count  = count_q;
    op_we     = 1'b0;
    op_re     = 1'b0;
    op_pop_ok = 1'b0;
    op_err    = ERR_NONE;
    waddr     = back_idx;
    raddr     = front_q;
    case (in_data_i.op)
      OP_PUSH_FRONT: begin
        waddr = front_dec;
        if (full) begin
          op_err = ERR_FULL;
        end else begin
          op_we    = 1'b1;
          op_front = front_dec;
          op_count = count_q + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          op_err = ERR_FULL;
        end else begin
          op_we    = 1'b1;
          op_count = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          op_err = ERR_EMPTY;
        end else begin
          op_re     = 1'b1;
          op_pop_ok = 1'b1;
          op_front  = front_inc;
          op_count  = count_q - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        raddr = last_idx;
        if (empty) begin
          op_err = ERR_EMPTY;
        end else begin
          op_re     = 1'b1;
          op_pop_ok = 1'b1;
          op_count  = count_q - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        op_front = '0;
        op_count = '0;
      end
      default: begin
      end
    endcase
  end

  // next state
  assign front_d     = accept ? op_front : front_q;
  assign count_d     = accept ? op_count : count_q;
  assign busy_d      = accept ? 1'b1 : (done ? 1'b0 : busy_q);
  assign out_valid_d = done ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // ring memory
  deq_ram #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .ADDR_W    (PTR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (accept && op_we),
    .waddr_i(waddr),
    .wdata_i(DATA_WIDTH'(in_data_i.push_value)),
    .re_i   (accept && op_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // status of the word in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_ok_q  <= op_pop_ok;
      err_q     <= op_err;
      res_cnt_q <= op_count;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q.pop_value  <= pop_ok_q ? 32'(rdata) : '0;
      out_q.error_code <= err_q;
      out_q.count      <= 5'(res_cnt_q);
      out_q.empty_flag <= (res_cnt_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/deq_checker.sv */
// port-level checks on the double-ended queue results, bound to the top level
module deq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input deq_pkg::deq_out_t out_data_o
);
  import deq_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // a failed operation returns no data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.error_code != ERR_NONE) |-> out_data_o.pop_value == '0)
    else $error("failed operation returned data");

  // empty flag agrees with the count
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_flag |-> out_data_o.count == '0)
    else $error("empty flag with non-zero count");

  // error kind agrees with the fill state
  a_err_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.error_code == ERR_EMPTY) && out_data_o.empty_flag) ||
      ((out_data_o.error_code == ERR_FULL) && !out_data_o.empty_flag) ||
      (out_data_o.error_code == ERR_NONE))
    else $error("error code inconsistent with fill state");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

/* bench/double_ended_queue_test.sv */
// self-checking testbench for the double-ended queue
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RANDOM_REQS = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  // one request word with the pacing that goes with it
  typedef struct {
    deq_in_t word;
    int      tx_idle;
    int      rx_stall;
    bit      drain_first;
    bit      hold_rx;
  } paced_req_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  deq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  deq_out_t out_data_o;

  paced_req_t queued_requests[$];
  deq_out_t   due_results[$];
  int         request_total = 0;
  int         taken_cnt     = 0;
  int         mismatch_cnt  = 0;
  int         quiet_cnt     = 0;

  // receiver pacing requests, written by the driver
  int rx_stall_pct = 0;
  int hold_seq     = 0;
  // hold-off progress, kept by the receiver
  int hold_seen    = 0;
  int hold_left    = 0;

  // shadow copy of the deque
  logic signed [31:0] ring_copy[DEPTH];
  logic [3:0]         head_idx   = '0;
  logic [4:0]         fill_level = '0;

  double_ended_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // apply one word to the shadow deque and give the result it should produce
  function automatic deq_out_t deq_apply(deq_in_t w);
    deq_out_t r;
    r = '0;
    r.error_code = ERR_NONE;
    case (w.op)
      OP_PUSH_FRONT: begin
        if (fill_level == 5'(DEPTH)) begin
          r.error_code = ERR_FULL;
        end else begin
          head_idx = head_idx - 4'd1;
          ring_copy[head_idx] = w.push_value;
          fill_level = fill_level + 5'd1;
        end
      end
      OP_PUSH_BACK: begin
        if (fill_level == 5'(DEPTH)) begin
          r.error_code = ERR_FULL;
        end else begin
          ring_copy[head_idx + fill_level[3:0]] = w.push_value;
          fill_level = fill_level + 5'd1;
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 5'd0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          r.pop_value = ring_copy[head_idx];
          head_idx = head_idx + 4'd1;
          fill_level = fill_level - 5'd1;
        end
      end
      OP_POP_BACK: begin
        if (fill_level == 5'd0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          r.pop_value = ring_copy[head_idx + 4'(fill_level - 5'd1)];
          fill_level = fill_level - 5'd1;
        end
      end
      OP_CLEAR: begin
        head_idx = '0;
        fill_level = '0;
      end
      default: begin
      end
    endcase
    r.count = fill_level;
    r.empty_flag = (fill_level == 5'd0);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic add_req(logic [2:0] op, logic [31:0] value, int tx, int rx,
                         bit drain = 1'b0, bit hold = 1'b0);
    paced_req_t p;
    p.word.op = op;
    p.word.push_value = value;
    p.tx_idle = tx;
    p.rx_stall = rx;
    p.drain_first = drain;
    p.hold_rx = hold;
    queued_requests.insert(queued_requests.size(), p);
    request_total++;
  endtask

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(19);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // directed part, then random segments of biased traffic
  task automatic build_stimulus();
    int seg;
    int tx;
    int rx;
    int push_w;
    int len;
    int r;
    logic [2:0] op;
    bit hold;
    // pops on an empty deque
    add_req(OP_POP_FRONT, 32'h1234_5678, 0, 0);
    add_req(OP_POP_BACK, 32'hffff_ffff, 0, 0);
    // extreme words at both ends
    add_req(OP_PUSH_FRONT, 32'h8000_0000, 0, 0);
    add_req(OP_PUSH_BACK, 32'h7fff_ffff, 0, 0);
    // unused op codes leave the contents alone
    add_req(3'd5, 32'hdead_beef, 0, 0);
    add_req(3'd6, 32'h0, 0, 0);
    add_req(3'd7, 32'hffff_ffff, 0, 0);
    add_req(OP_POP_BACK, 32'h0, 0, 0);
    add_req(OP_POP_FRONT, 32'h0, 0, 0);
    // fill to the brim from both sides, wrapping the head pointer
    for (int i = 0; i < DEPTH; i++) begin
      add_req((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
              (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : $urandom, 0, 0);
    end
    // push on a full deque is dropped, then clear
    add_req(OP_PUSH_FRONT, 32'h5555_aaaa, 0, 0);
    add_req(OP_CLEAR, 32'h0, 0, 0);

    seg = 0;
    while (request_total < RANDOM_REQS + 30) begin
      case (seg % 4)
        0: begin tx = 0;  rx = 0;  end
        1: begin tx = 69; rx = 0;  end
        2: begin tx = 0;  rx = 69; end
        default: begin tx = 37; rx = 37; end
      endcase
      hold = (seg % 8 == 4);
      case (seg % 3)
        0: push_w = 75;
        1: push_w = 25;
        default: push_w = 50;
      endcase
      if (hold) push_w = 85;
      len = $urandom_range(20, 50);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 4) begin
          op = OP_CLEAR;
        end else if (r < 7) begin
          op = 3'($urandom_range(5, 7));
        end else if ($urandom_range(99) < push_w) begin
          op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        end
        add_req(op, pick_word(), tx, rx, (i == 0) && (seg % 4 == 1), (i == 0) && hold);
      end
      seg++;
    end
  endtask

  // driver: offers queued words and predicts each accepted one
  always @(posedge clk_i) begin : drive_requests
    bit         fire;
    bit         show;
    paced_req_t nx;
    if (rst_ni) begin
      fire = in_valid_i && in_ready_o;
      show = 1'b0;
      if (fire) begin
        due_results.insert(due_results.size(), deq_apply(in_data_i));
        taken_cnt++;
      end
      if (!in_valid_i || fire) begin
        if (queued_requests.size() != 0) begin
          nx = queued_requests[0];
          if (!(nx.drain_first && due_results.size() != 0) &&
              $urandom_range(99) >= nx.tx_idle) begin
            show = 1'b1;
          end
        end
        if (show) begin
          queued_requests.delete(0);
          in_data_i <= nx.word;
          in_valid_i <= 1'b1;
          rx_stall_pct <= nx.rx_stall;
          if (nx.hold_rx) hold_seq <= hold_seq + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver readiness: random stalls plus the occasional long hold-off
  always @(posedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (hold_seq != hold_seen) begin
        hold_seen <= hold_seq;
        hold_left <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // monitor: checks each result word against the oldest prediction
  always @(posedge clk_i) begin : check_results
    deq_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing due, count %0d",
                                    out_data_o.count));
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (out_data_o.pop_value !== want.pop_value)
            report_mismatch($sformatf("pop_value got %h want %h",
                                      out_data_o.pop_value, want.pop_value));
          if (out_data_o.error_code !== want.error_code)
            report_mismatch($sformatf("error_code got %0d want %0d",
                                      out_data_o.error_code, want.error_code));
          if (out_data_o.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d",
                                      out_data_o.count, want.count));
          if (out_data_o.empty_flag !== want.empty_flag)
            report_mismatch($sformatf("empty_flag got %0d want %0d",
                                      out_data_o.empty_flag, want.empty_flag));
        end
      end
      // watchdog on cycles with no handshake on either side
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("FAIL double_ended_queue");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // reset, run and final verdict
  initial begin
    build_stimulus();
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (taken_cnt == request_total && due_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule
